### rtl/websocket_frame_receiver_top_assert.svh
// assertion macros used by the frame receiver parser rtl
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication under reset
`define WSFR_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("wsfr check failed");

// next-cycle implication under reset
`define WSFR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("wsfr check failed");

`endif

### rtl/wsfr_pkg.sv
// types, constants and helper functions of the websocket frame receiver
package wsfr_pkg;

    localparam int LENGTH_BITS_DEF = 64;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_ERROR
    } phase_t;

    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_ONGOING  = 3'd1,
        ST_DONE     = 3'd2,
        ST_PROTO    = 3'd3,
        ST_UNMASKED = 3'd4
    } status_t;

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [6:0] LEN_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN_CODE16   = 7'd126;
    localparam logic [6:0] LEN_CODE64   = 7'd127;

    localparam logic [3:0] EXT_NONE = 4'd0;
    localparam logic [3:0] EXT_16   = 4'd2;
    localparam logic [3:0] EXT_64   = 4'd8;
    localparam logic [3:0] HDR_BASE = 4'd6;

    typedef struct packed {
        logic [63:0] byte_offset;
        logic [15:0] close_code;
        logic        final_flag;
        logic [3:0]  frame_opcode;
        status_t     status;
        logic        payload_valid;
        logic [7:0]  out_byte;
    } result_t;

    function automatic logic opcode_known(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG};
    endfunction

    function automatic logic close_code_ok(input logic [15:0] c);
        return c inside {[16'd1000:16'd1003], [16'd1007:16'd1011],
                         [16'd3000:16'd3999], [16'd4000:16'd4999]};
    endfunction

endpackage

### rtl/wsfr_parser.sv
// frame header parser, unmasking and close code check for one byte per cycle while step is high
module wsfr_parser #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        in_byte,
    output wsfr_pkg::result_t result
);
    import wsfr_pkg::*;

    localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);
    localparam logic [LENGTH_BITS-1:0] CNT_TWO = LENGTH_BITS'(2);

    phase_t                 phase_reg, phase_next;
    logic [3:0]             hdr_cnt_reg, hdr_cnt_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   final_reg, final_next;
    logic [6:0]             len_code_reg, len_code_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   len_ovf_reg, len_ovf_next;
    logic [31:0]            key_reg, key_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [15:0]            close_reg, close_next;
    status_t                err_reg, err_next;
    logic                   fault_reg, fault_next;

    logic [3:0]             ext;
    logic [3:0]             hdr_cnt_inc;
    logic                   raise;
    status_t                raise_code;
    status_t                status;
    logic [7:0]             key_byte;
    logic [7:0]             unmasked;
    logic [15:0]            code_full;
    logic                   payload_valid;
    logic [LENGTH_BITS-1:0] offset;

    always_comb
    begin
        case (len_code_reg)
            LEN_CODE16: ext = EXT_16;
            LEN_CODE64: ext = EXT_64;
            default:    ext = EXT_NONE;
        endcase
    end

    assign hdr_cnt_inc = hdr_cnt_reg + 4'd1;

    always_comb
    begin
        case (count_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign unmasked  = in_byte ^ key_byte;
    assign code_full = close_reg | {8'h00, unmasked};

    // next state
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        opcode_next   = opcode_reg;
        final_next    = final_reg;
        len_code_next = len_code_reg;
        len_next      = len_reg;
        len_ovf_next  = len_ovf_reg;
        key_next      = key_reg;
        count_next    = count_reg;
        close_next    = close_reg;
        err_next      = err_reg;
        fault_next    = fault_reg;
        raise         = 1'b0;
        raise_code    = ST_PROTO;
        status        = ST_PENDING;
        payload_valid = 1'b0;
        offset        = '0;
        if (step)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_cnt_reg == 4'd0)
                    begin
                        opcode_next  = in_byte[3:0];
                        final_next   = in_byte[7];
                        count_next   = '0;
                        close_next   = '0;
                        len_next     = '0;
                        len_ovf_next = 1'b0;
                        key_next     = '0;
                        fault_next   = !opcode_known(in_byte[3:0]) || (in_byte[6:4] != 3'd0)
                                       || (in_byte[3] && !in_byte[7]);
                    end
                    else if (hdr_cnt_reg == 4'd1)
                    begin
                        len_code_next = in_byte[6:0];
                        if (fault_reg || (opcode_reg[3] && in_byte[6:0] > LEN_CTRL_MAX))
                        begin
                            raise = 1'b1;
                        end
                        else if (!in_byte[7])
                        begin
                            raise      = 1'b1;
                            raise_code = ST_UNMASKED;
                        end
                        else if (in_byte[6:0] < LEN_CODE16)
                        begin
                            len_next = LENGTH_BITS'(in_byte[6:0]);
                        end
                    end
                    else if (hdr_cnt_reg < 4'd2 + ext)
                    begin
                        len_next     = {len_reg[LENGTH_BITS-9:0], in_byte};
                        len_ovf_next = len_ovf_reg || (|len_reg[LENGTH_BITS-1:LENGTH_BITS-8]);
                        if (hdr_cnt_reg == 4'd1 + ext && (len_ovf_next
                            || (LENGTH_BITS == 64 && len_next[LENGTH_BITS-1])))
                        begin
                            raise = 1'b1;
                        end
                    end
                    else
                    begin
                        key_next = {key_reg[23:0], in_byte};
                    end
                    if (!raise)
                    begin
                        hdr_cnt_next = hdr_cnt_inc;
                        if (hdr_cnt_inc == HDR_BASE + ext)
                        begin
                            hdr_cnt_next = 4'd0;
                            if (opcode_reg == OP_CLOSE && len_next == CNT_ONE)
                            begin
                                raise = 1'b1;
                            end
                            else if (len_next == '0)
                            begin
                                status = ST_DONE;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (opcode_reg == OP_CLOSE && count_reg == '0)
                    begin
                        close_next = {unmasked, 8'h00};
                    end
                    else if (opcode_reg == OP_CLOSE && count_reg == CNT_ONE)
                    begin
                        close_next = code_full;
                        raise      = !close_code_ok(code_full);
                    end
                    if (!raise)
                    begin
                        count_next    = count_reg + CNT_ONE;
                        payload_valid = 1'b1;
                        offset        = count_reg;
                        if (count_next >= len_reg)
                        begin
                            status       = ST_DONE;
                            phase_next   = PH_HEADER;
                            hdr_cnt_next = 4'd0;
                        end
                        else
                        begin
                            status = ST_ONGOING;
                        end
                    end
                end
                default:
                begin
                end
            endcase
            if (raise)
            begin
                phase_next = PH_ERROR;
                err_next   = raise_code;
            end
        end
    end

    // result of the item in flight
    always_comb
    begin
        result              = '0;
        result.frame_opcode = opcode_next;
        result.final_flag   = final_next;
        if (phase_next == PH_ERROR)
        begin
            result.status = err_next;
        end
        else
        begin
            result.status        = status;
            result.payload_valid = payload_valid;
            result.out_byte      = payload_valid ? unmasked : 8'h00;
            result.byte_offset   = 64'(offset);
            result.close_code    = (opcode_next == OP_CLOSE && count_next >= CNT_TWO)
                                   ? close_next : 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_cnt_reg  <= '0;
            opcode_reg   <= '0;
            final_reg    <= 1'b0;
            len_code_reg <= '0;
            len_reg      <= '0;
            len_ovf_reg  <= 1'b0;
            key_reg      <= '0;
            count_reg    <= '0;
            close_reg    <= '0;
            err_reg      <= ST_PENDING;
            fault_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_cnt_reg  <= hdr_cnt_next;
            opcode_reg   <= opcode_next;
            final_reg    <= final_next;
            len_code_reg <= len_code_next;
            len_reg      <= len_next;
            len_ovf_reg  <= len_ovf_next;
            key_reg      <= key_next;
            count_reg    <= count_next;
            close_reg    <= close_next;
            err_reg      <= err_next;
            fault_reg    <= fault_next;
        end
    end

`include "websocket_frame_receiver_top_assert.svh"

    `WSFR_ASSERT_NEXT(a_error_sticky, clk, rst_n, phase_reg == PH_ERROR, phase_reg == PH_ERROR)
    `WSFR_ASSERT_IMPLY(a_error_code, clk, rst_n, phase_reg == PH_ERROR,
        err_reg == ST_PROTO || err_reg == ST_UNMASKED)
    `WSFR_ASSERT_IMPLY(a_payload_no_hdr_cnt, clk, rst_n, phase_reg == PH_PAYLOAD,
        hdr_cnt_reg == 4'd0)
    `WSFR_ASSERT_IMPLY(a_valid_status, clk, rst_n, result.payload_valid,
        result.status == ST_ONGOING || result.status == ST_DONE)

endmodule

### rtl/websocket_frame_receiver_top.sv
// websocket frame receiver top level with input and result registers
// usage:
//   s_axis carries the client-to-server stream, one raw byte per item
//   m_axis returns exactly one result item for every input byte
//   each result holds the unmasked byte, the frame status, opcode, fin bit,
//   close code and payload offset; tuser flags a payload byte
// timing:
//   an item accepted into the input register passes through the parser logic
//   into the result register, which drives m_axis
//   one item per cycle sustained while m_axis_tready stays high; the header, unmask
//   and length compare logic is combinational between input and result registers
// reset:
//   rst_n clears the pipeline valids and puts the parser in the header state
//   with all counters, key and errors cleared
// stall:
//   while m_axis_tready is low the result register holds, and s_axis_tready
//   drops once the input register is also full; no item is lost
//   after a protocol or unmasked error the status stays sticky until reset
module websocket_frame_receiver_top #(
    parameter int LENGTH_BITS = wsfr_pkg::LENGTH_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // out_byte, status, frame_opcode, final_flag,
                                       // close_code, byte_offset
    output logic        m_axis_tuser   // payload_valid
);
    import wsfr_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    result;
    logic       out_ready;
    logic       step;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
        if (step)
        begin
            out_reg <= result;
        end
    end

    wsfr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (in_byte_reg),
        .result  (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.payload_valid;
    assign m_axis_tdata  = {out_reg.byte_offset, out_reg.close_code, out_reg.final_flag,
                            out_reg.frame_opcode, out_reg.status, out_reg.out_byte};

endmodule

### tb/websocket_frame_receiver_top_tb.sv
// testbench for the websocket frame receiver: framed byte streams checked against a parser model
`timescale 1ns / 1ps

module websocket_frame_receiver_top_tb;
    import wsfr_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEF;

    typedef enum int {LEN7, LEN16, LEN64} len_form_t;
    typedef enum int {
        F_OPCODE,
        F_RSV,
        F_CTRL_FRAG,
        F_CTRL_LONG,
        F_UNMASKED,
        F_LEN_MSB,
        F_CLOSE_ONE,
        F_CLOSE_CODE,
        F_NONE
    } fault_t;
    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [95:0] m_axis_tdata;   // out_byte, status, frame_opcode, final_flag,
                                 // close_code, byte_offset
    logic        m_axis_tuser;   // payload_valid

    websocket_frame_receiver_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // parser model state
    phase_t      rx_phase;
    logic [3:0]  hdr_idx;
    logic [3:0]  rx_op;
    logic        rx_fin;
    logic [6:0]  rx_len_code;
    logic [63:0] rx_len;
    logic [31:0] rx_key;
    logic [63:0] rx_count;
    logic [15:0] rx_close;
    status_t     rx_err;
    logic        rx_hdr_bad;

    result_t predicted_results[$];
    int      err_count;
    int      bytes_sent;
    int      sender_idle_pct;
    int      recv_stall_pct;
    int      hold_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int ext_count();
        case (rx_len_code)
            LEN_CODE16: return int'(EXT_16);
            LEN_CODE64: return int'(EXT_64);
            default:    return int'(EXT_NONE);
        endcase
    endfunction

    function automatic logic opcode_valid(input logic [3:0] op);
        case (op)
            OP_CONT, OP_TEXT, OP_BIN, OP_CLOSE, OP_PING, OP_PONG: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic close_code_allowed(input logic [15:0] c);
        return (c >= 16'd1000 && c <= 16'd1003) || (c >= 16'd1007 && c <= 16'd1011) ||
               (c >= 16'd3000 && c <= 16'd4999);
    endfunction

    function automatic byte_q_t random_bytes(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic byte_q_t close_payload(input logic [15:0] code, input int reason_len);
        byte_q_t q;
        q = random_bytes(reason_len);
        q.push_front(code[7:0]);
        q.push_front(code[15:8]);
        return q;
    endfunction

    function automatic logic [15:0] random_close_code();
        case ($urandom_range(0, 3))
            0:       return 16'(1000 + $urandom_range(0, 3));
            1:       return 16'(1007 + $urandom_range(0, 4));
            2:       return 16'(3000 + $urandom_range(0, 999));
            default: return 16'(4000 + $urandom_range(0, 999));
        endcase
    endfunction

    task automatic raise_fault(input status_t code);
        rx_phase = PH_ERROR;
        rx_err   = code;
    endtask

    task automatic parse_byte(input logic [7:0] b, output result_t r);
        int          n;
        int          sh;
        logic [63:0] off;
        logic [7:0]  u;
        logic        bad;
        status_t     st;
        r  = '0;
        st = ST_PENDING;
        if (rx_phase == PH_HEADER)
        begin
            n = int'(hdr_idx);
            if (n == 0)
            begin
                rx_op      = b[3:0];
                rx_fin     = b[7];
                rx_count   = '0;
                rx_close   = '0;
                rx_len     = '0;
                rx_key     = '0;
                rx_hdr_bad = !opcode_valid(b[3:0]) || b[6:4] != 3'b000 || (b[3] && !b[7]);
            end
            else if (n == 1)
            begin
                rx_len_code = b[6:0];
                if (rx_hdr_bad || (rx_op[3] && rx_len_code > LEN_CTRL_MAX))
                    raise_fault(ST_PROTO);
                else if (!b[7])
                    raise_fault(ST_UNMASKED);
                else if (rx_len_code < LEN_CODE16)
                    rx_len = 64'(rx_len_code);
            end
            else if (n < 2 + ext_count())
            begin
                rx_len = {rx_len[55:0], b};
                if (n == 1 + ext_count() && (rx_len[63] || (rx_len >> LEN_BITS) != 0))
                    raise_fault(ST_PROTO);
            end
            else
            begin
                rx_key = {rx_key[23:0], b};
            end
            if (rx_phase == PH_HEADER)
            begin
                hdr_idx = 4'(n + 1);
                if (n + 1 == int'(HDR_BASE) + ext_count())
                begin
                    hdr_idx = '0;
                    if (rx_op == OP_CLOSE && rx_len == 64'd1)
                        raise_fault(ST_PROTO);
                    else if (rx_len == 64'd0)
                        st = ST_DONE;
                    else
                        rx_phase = PH_PAYLOAD;
                end
            end
        end
        else if (rx_phase == PH_PAYLOAD)
        begin
            off = rx_count;
            sh  = (3 - int'(off[1:0])) * 8;
            u   = b ^ rx_key[sh +: 8];
            bad = 1'b0;
            if (rx_op == OP_CLOSE)
            begin
                if (off == 64'd0)
                    rx_close = {u, 8'h00};
                else if (off == 64'd1)
                begin
                    rx_close[7:0] = u;
                    bad = !close_code_allowed(rx_close);
                end
            end
            if (bad)
                raise_fault(ST_PROTO);
            else
            begin
                rx_count        = off + 64'd1;
                r.out_byte      = u;
                r.payload_valid = 1'b1;
                r.byte_offset   = off;
                if (rx_count >= rx_len)
                begin
                    st       = ST_DONE;
                    rx_phase = PH_HEADER;
                    hdr_idx  = '0;
                end
                else
                    st = ST_ONGOING;
            end
        end
        if (rx_phase == PH_ERROR)
        begin
            r              = '0;
            r.status       = rx_err;
            r.frame_opcode = rx_op;
            r.final_flag   = rx_fin;
        end
        else
        begin
            r.status       = st;
            r.frame_opcode = rx_op;
            r.final_flag   = rx_fin;
            r.close_code   = (rx_op == OP_CLOSE && rx_count >= 64'd2) ? rx_close : 16'd0;
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge clk); while (!s_axis_tready);
        parse_byte(b, r);
        predicted_results.push_back(r);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [3:0] opc, input logic fin_b, input len_form_t form,
                              input byte_q_t data);
        logic [63:0] len;
        logic [31:0] key;
        len = 64'(data.size());
        key = $urandom();
        send_byte({fin_b, 3'b000, opc});
        case (form)
            LEN16:
            begin
                send_byte({1'b1, LEN_CODE16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            LEN64:
            begin
                send_byte({1'b1, LEN_CODE64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[i*8 +: 8]);
            end
            default: send_byte({1'b1, len[6:0]});
        endcase
        for (int i = 0; i < 4; i++)
            send_byte(key[31 - 8*i -: 8]);
        foreach (data[i])
            send_byte(data[i] ^ key[31 - 8*(i % 4) -: 8]);
    endtask

    task automatic send_random_frame();
        int        kind;
        int        n;
        int        pick;
        logic [3:0] opc;
        len_form_t form;
        kind = $urandom_range(0, 99);
        if (kind < 60)
        begin
            case ($urandom_range(0, 2))
                0:       opc = OP_CONT;
                1:       opc = OP_TEXT;
                default: opc = OP_BIN;
            endcase
            form = LEN7;
            n    = $urandom_range(0, 12);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = $urandom_range(100, 125);
            else if (pick < 3)
            begin
                form = LEN16;
                n    = $urandom_range(0, 40);
            end
            else if (pick < 4)
            begin
                form = LEN64;
                n    = $urandom_range(0, 40);
            end
            send_frame(opc, 1'($urandom_range(0, 1)), form, random_bytes(n));
        end
        else if (kind < 80)
        begin
            opc = $urandom_range(0, 1) ? OP_PING : OP_PONG;
            n   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 8);
            send_frame(opc, 1'b1, LEN7, random_bytes(n));
        end
        else if ($urandom_range(0, 4) == 0)
            send_frame(OP_CLOSE, 1'b1, LEN7, random_bytes(0));
        else
            send_frame(OP_CLOSE, 1'b1, LEN7,
                       close_payload(random_close_code(), $urandom_range(0, 6)));
    endtask

    task automatic test_data_frames();
        sender_idle_pct = 12;
        recv_stall_pct  = 12;
        send_frame(OP_TEXT, 1'b1, LEN7, '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C});
        send_frame(OP_BIN, 1'b0, LEN7, random_bytes(6));
        send_frame(OP_CONT, 1'b0, LEN16, random_bytes(3));
        send_frame(OP_CONT, 1'b1, LEN64, random_bytes(9));
        send_frame(OP_TEXT, 1'b1, LEN7, random_bytes(0));
        send_frame(OP_BIN, 1'b1, LEN64, random_bytes(0));
        send_frame(OP_PING, 1'b1, LEN7, random_bytes(0));
        send_frame(OP_PONG, 1'b1, LEN7, random_bytes(1));
        send_frame(OP_PING, 1'b1, LEN7, random_bytes(125));
        send_frame(OP_BIN, 1'b1, LEN16, random_bytes(30));
    endtask

    task automatic test_close_codes();
        logic [15:0] codes[8];
        codes = '{16'd1000, 16'd1003, 16'd1007, 16'd1011,
                  16'd3000, 16'd3999, 16'd4000, 16'd4999};
        sender_idle_pct = 12;
        recv_stall_pct  = 12;
        send_frame(OP_CLOSE, 1'b1, LEN7, random_bytes(0));
        foreach (codes[i])
            send_frame(OP_CLOSE, 1'b1, LEN7, close_payload(codes[i], $urandom_range(0, 4)));
    endtask

    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 60;
        repeat (4) send_frame(OP_BIN, 1'b1, LEN7, random_bytes(10));
    endtask

    task automatic test_random_stream(input int total);
        int idle_tab[4];
        int stall_tab[4];
        int start;
        idle_tab  = '{0, 80, 0, 12};
        stall_tab = '{0, 0, 80, 12};
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_tab[p];
            recv_stall_pct  = stall_tab[p];
            start = bytes_sent;
            while (bytes_sent - start < total / 4)
                send_random_frame();
        end
    endtask

    // at most one fault per run since errors only clear on reset
    task automatic test_protocol_error();
        fault_t      kind;
        logic [3:0]  opc;
        logic [15:0] code;
        sender_idle_pct = 12;
        recv_stall_pct  = 12;
        kind = fault_t'($urandom_range(0, int'(F_NONE)));
        case (kind)
            F_OPCODE:
            begin
                opc = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
                send_byte({1'($urandom_range(0, 1)), 3'b000, opc});
                send_byte({1'b1, 7'($urandom_range(0, 127))});
            end
            F_RSV:
            begin
                send_byte({1'b1, 3'($urandom_range(1, 7)), OP_TEXT});
                send_byte({1'b1, 7'd4});
            end
            F_CTRL_FRAG:
            begin
                send_byte({1'b0, 3'b000, OP_PING});
                send_byte({1'b1, 7'd0});
            end
            F_CTRL_LONG:
            begin
                send_byte({1'b1, 3'b000, OP_CLOSE});
                send_byte({1'b1, $urandom_range(0, 1) ? LEN_CODE16 : LEN_CODE64});
            end
            F_UNMASKED:
            begin
                send_byte({1'b1, 3'b000, OP_BIN});
                send_byte({1'b0, 7'($urandom_range(0, 125))});
            end
            F_LEN_MSB:
            begin
                send_byte({1'b1, 3'b000, OP_BIN});
                send_byte({1'b1, LEN_CODE64});
                send_byte(8'h80 | 8'($urandom_range(0, 255)));
                repeat (7) send_byte(8'($urandom_range(0, 255)));
            end
            F_CLOSE_ONE: send_frame(OP_CLOSE, 1'b1, LEN7, random_bytes(1));
            F_CLOSE_CODE:
            begin
                case ($urandom_range(0, 7))
                    0: code = 16'd999;
                    1: code = 16'd1004;
                    2: code = 16'd1006;
                    3: code = 16'd1012;
                    4: code = 16'd2999;
                    5: code = 16'd5000;
                    default:
                    begin
                        do code = 16'($urandom_range(0, 65535));
                        while (close_code_allowed(code));
                    end
                endcase
                send_frame(OP_CLOSE, 1'b1, LEN7, close_payload(code, $urandom_range(0, 3)));
            end
            default: ;
        endcase
        repeat (24) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.out_byte      = m_axis_tdata[7:0];
            got.status        = status_t'(m_axis_tdata[10:8]);
            got.frame_opcode  = m_axis_tdata[14:11];
            got.final_flag    = m_axis_tdata[15];
            got.close_code    = m_axis_tdata[31:16];
            got.byte_offset   = m_axis_tdata[95:32];
            got.payload_valid = m_axis_tuser;
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual tdata=%h tuser=%b",
                         $time, m_axis_tdata, m_axis_tuser);
                err_count++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("out_byte", want.out_byte, got.out_byte);
                check_field("payload_valid", want.payload_valid, got.payload_valid);
                check_field("status", want.status, got.status);
                check_field("frame_opcode", want.frame_opcode, got.frame_opcode);
                check_field("final_flag", want.final_flag, got.final_flag);
                check_field("close_code", want.close_code, got.close_code);
                check_field("byte_offset", want.byte_offset, got.byte_offset);
            end
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        err_count       = 0;
        bytes_sent      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        rx_phase        = PH_HEADER;
        hdr_idx         = '0;
        rx_op           = '0;
        rx_fin          = 1'b0;
        rx_len_code     = '0;
        rx_len          = '0;
        rx_key          = '0;
        rx_count        = '0;
        rx_close        = '0;
        rx_err          = ST_PENDING;
        rx_hdr_bad      = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_data_frames();
        test_close_codes();
        test_output_backpressure();
        test_random_stream(160);
        test_protocol_error();

        @(negedge clk);
        s_axis_tvalid  <= 1'b0;
        recv_stall_pct = 0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0 && predicted_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### websocket_frame_receiver_top.f
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/wsfr_parser.sv
rtl/websocket_frame_receiver_top.sv
tb/websocket_frame_receiver_top_tb.sv
